// ===== rtl/tcsf_pkg.sv =====
// Package for the terrain cell slope-failure core: widths, codes, lane and
// item types, and the neighbour spacing-class table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcsf_pkg;

  // Height width (Q14.4 by default) and the derived field widths
  localparam int HB      = 18;
  localparam int NB_W    = HB + 1;        // one neighbour: height plus marker
  localparam int NUM_NB  = 8;
  localparam int RW      = 32;            // register and reciprocal width
  localparam int PROD_W  = HB + RW;       // drop times reciprocal, Q.28
  localparam int QB      = HB + 1;        // quotient bits kept by the divider
  localparam int NUM_W   = RW + 12;       // min_slope scaled by 4096
  localparam int REM_W   = RW + 1;
  localparam int MRG_LAT = 3;             // registered merge tree levels
  // lane, merge, divider entry, divider steps, output register
  localparam int LAT     = 1 + MRG_LAT + 1 + QB + 1;
  // decision hold stages, lined up with the quotient
  localparam int DLY     = QB - 1;

  localparam logic [HB-1:0] HMAX = {HB{1'b1}};

  // Reset values of the configuration registers
  localparam logic [RW-1:0] MIN_SLOPE_RST  = 32'd65536;
  localparam logic [RW-1:0] SPAN_RECIP_RST = 32'd16384;
  localparam logic [RW-1:0] INV_NS_RST     = 32'd16777216;

  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_STABLE = 2'd1,
    OUT_FAIL   = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    REG_MIN_SLOPE  = 2'd0,
    REG_SPAN_RECIP = 2'd1,
    REG_INV_NS     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_DIAG = 2'd0,
    CLS_EW   = 2'd1,
    CLS_NS   = 2'd2
  } dist_cls_e;

  // One lane's finding: slope, neighbour height, spacing reciprocal used
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [HB-1:0]     nh;
    logic [RW-1:0]     recip;
  } lane_t;

  // Center-cell fields that ride along the pipeline
  typedef struct packed {
    logic [HB-1:0] h;
    logic          marked;
    logic [HB-1:0] orig;
    logic [RW-1:0] stable;
    logic [15:0]   rnd;
  } item_t;

  // Decided result, waiting for the divider
  typedef struct packed {
    outcome_e      outcome;
    logic [HB-1:0] h;
    logic          marked;
    logic [HB-1:0] orig;
    logic [RW-1:0] stable;
    logic [HB-1:0] best_h;
  } dec_t;

  // Order NE, E, SE, S, SW, W, NW, N
  function automatic dist_cls_e dist_class(input int k);
    dist_cls_e c;
    unique case (k)
      1, 5:    c = CLS_EW;
      3, 7:    c = CLS_NS;
      default: c = CLS_DIAG;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/terrain_cell_slope_failure_core.sv =====
// Terrain cell slope-failure core: eight slope lanes, merge tree, decision
// stages and the pipelined lowering divider. Depends on tcsf_pkg, tcsf_lane,
// tcsf_merge and tcsf_div.
//
// Usage:
//   Input: present a cell on the input ports with start_i high; the word is
//   taken at a rising edge where start_i is high and busy_o is low. busy_o is
//   high only while in reset and until the first edge after, so a new word
//   can be taken every cycle.
//   Output: each word gives one result, shown for exactly one cycle with
//   done_o high; the word passes the lane product register, the merge tree
//   levels, the divider entry, the divider steps and the output register;
//   the decision stages run beside the divider.
//   Results leave in the order the words came in; there is no stall path,
//   the receiver takes every result in the cycle it is shown.
//   Throughput: one word per cycle. The depth is set by the restoring
//   divider, one quotient bit per stage for HB+1 bits.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write a register at a
//   rising edge; write only while no word is in flight. Index 3 is ignored.
//   Reset: rst_ni low clears the pipeline valid bits and loads the register
//   reset values; no result is shown for words in flight at reset.
`timescale 1ns / 1ps
`default_nettype none

module terrain_cell_slope_failure_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [tcsf_pkg::RW-1:0]    cfg_wdata_i,
  // command
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [tcsf_pkg::HB-1:0]    center_height_i,
  input  wire logic                       center_marked_i,
  input  wire logic [tcsf_pkg::HB-1:0]    center_original_i,
  input  wire logic [tcsf_pkg::RW-1:0]    center_stable_slope_i,
  input  wire logic [3*tcsf_pkg::NB_W-1:0] neighbours_first_i,
  input  wire logic [3*tcsf_pkg::NB_W-1:0] neighbours_second_i,
  input  wire logic [2*tcsf_pkg::NB_W-1:0] neighbours_third_i,
  input  wire logic [tcsf_pkg::RW-1:0]    inv_dist_ew_i,
  input  wire logic [tcsf_pkg::RW-1:0]    inv_dist_diag_i,
  input  wire logic [15:0]                random_value_i,
  // result
  output logic                            done_o,
  output logic [1:0]                      outcome_o,
  output logic [tcsf_pkg::HB-1:0]         new_height_o,
  output logic                            new_marked_o,
  output logic [tcsf_pkg::HB-1:0]         new_original_o,
  output logic [tcsf_pkg::RW-1:0]         new_stable_slope_o
);
  import tcsf_pkg::*;

  // ---------------- configuration and command ----------------
  logic [RW-1:0] min_slope_q, span_recip_q, inv_ns_q;
  logic          busy_q;
  logic          acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_slope_q  <= MIN_SLOPE_RST;
      span_recip_q <= SPAN_RECIP_RST;
      inv_ns_q     <= INV_NS_RST;
      busy_q       <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MIN_SLOPE:  min_slope_q  <= cfg_wdata_i;
          REG_SPAN_RECIP: span_recip_q <= cfg_wdata_i;
          REG_INV_NS:     inv_ns_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign busy_o = busy_q;
  assign acc    = start_i && !busy_q;

  // ---------------- lanes ----------------
  logic [NUM_NB*NB_W-1:0] nb_all;
  lane_t                  lane [NUM_NB];
  lane_t                  win;

  assign nb_all = {neighbours_third_i, neighbours_second_i, neighbours_first_i};

  for (genvar k = 0; k < NUM_NB; k++) begin : g_lane
    logic [RW-1:0] recip;

    always_comb begin
      unique case (dist_class(k))
        CLS_EW:  recip = inv_dist_ew_i;
        CLS_NS:  recip = inv_ns_q;
        default: recip = inv_dist_diag_i;
      endcase
    end

    tcsf_lane u_lane (
      .clk_i  (clk_i),
      .h_i    (center_height_i),
      .nb_i   (nb_all[k*NB_W +: NB_W]),
      .recip_i(recip),
      .lane_o (lane[k])
    );
  end

  tcsf_merge u_merge (
    .clk_i (clk_i),
    .lane_i(lane),
    .win_o (win)
  );

  // ---------------- item sideband through lanes and merge ----------------
  item_t item_q [1 + MRG_LAT];
  logic  vld_q  [1 + MRG_LAT];
  item_t item_in;

  assign item_in = '{h: center_height_i, marked: center_marked_i,
                     orig: center_original_i, stable: center_stable_slope_i,
                     rnd: random_value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MRG_LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= acc;
      for (int i = 1; i <= MRG_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    item_q[0] <= item_in;
    for (int i = 1; i <= MRG_LAT; i++) item_q[i] <= item_q[i-1];
  end

  // ---------------- threshold and slope terms ----------------
  item_t             it4;
  logic [RW-1:0]     thr;
  logic [PROD_W-1:0] thr_sh;
  logic [PROD_W-1:0] diff;
  logic [RW-1:0]     sh16_d, diff16_d;

  function automatic logic [RW-1:0] sat_shift(input logic [PROD_W-1:0] v);
    logic [PROD_W-13:0] hi;
    hi = v[PROD_W-1:12];
    return (hi > (PROD_W-12)'({RW{1'b1}})) ? {RW{1'b1}} : hi[RW-1:0];
  endfunction

  always_comb begin
    it4      = item_q[MRG_LAT];
    thr      = (it4.stable > min_slope_q) ? it4.stable : min_slope_q;
    thr_sh   = PROD_W'({thr, 12'b0});
    diff     = win.prod - thr_sh;
    sh16_d   = sat_shift(win.prod);
    diff16_d = sat_shift(diff);
  end

  logic          vld5_q, vld6_q;
  item_t         it5_q, it6_q;
  logic          skip5_q, skip6_q;
  logic [RW-1:0] sh16_5_q, sh16_6_q, diff16_q;
  logic [HB-1:0] bh5_q, bh6_q;
  logic [63:0]   prob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
    end else begin
      vld5_q <= vld_q[MRG_LAT];
      vld6_q <= vld5_q;
    end
  end

  // Skip: no data, no slope, or slope under the threshold
  always_ff @(posedge clk_i) begin
    it5_q    <= it4;
    skip5_q  <= (it4.h == '0) || (win.prod < thr_sh);
    sh16_5_q <= sh16_d;
    diff16_q <= diff16_d;
    bh5_q    <= win.nh;
    it6_q    <= it5_q;
    skip6_q  <= skip5_q;
    sh16_6_q <= sh16_5_q;
    bh6_q    <= bh5_q;
    prob_q   <= 64'(diff16_q) * 64'(span_recip_q);
  end

  // Lowering step runs for every word; used only on failure
  logic [QB-1:0] quo;
  logic          ovf;

  tcsf_div u_div (
    .clk_i(clk_i),
    .dvd_i(min_slope_q),
    .dvs_i(win.recip),
    .quo_o(quo),
    .ovf_o(ovf)
  );

  // ---------------- outcome decision ----------------
  dec_t dec_d;
  logic fail;

  always_comb begin
    fail = !skip6_q && (sh16_6_q != '0 || prob_q != '0) &&
           (64'({it6_q.rnd, 16'b0}) < prob_q);
    dec_d.h      = it6_q.h;
    dec_d.marked = it6_q.marked;
    dec_d.orig   = it6_q.orig;
    dec_d.stable = it6_q.stable;
    dec_d.best_h = bh6_q;
    priority if (skip6_q) begin
      dec_d.outcome = OUT_NONE;
    end else if (fail) begin
      dec_d.outcome = OUT_FAIL;
      dec_d.marked  = 1'b0;
      dec_d.orig    = (it6_q.orig != '0) ? it6_q.orig : it6_q.h;
    end else begin
      dec_d.outcome = OUT_STABLE;
      dec_d.stable  = sh16_6_q;
    end
  end

  // Hold decisions until the quotient arrives
  dec_t dly_q     [DLY];
  logic dly_vld_q [DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLY; i++) dly_vld_q[i] <= 1'b0;
    end else begin
      dly_vld_q[0] <= vld6_q;
      for (int i = 1; i < DLY; i++) dly_vld_q[i] <= dly_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q[0] <= dec_d;
    for (int i = 1; i < DLY; i++) dly_q[i] <= dly_q[i-1];
  end

  // ---------------- output register ----------------
  dec_t          fin;
  logic [HB+1:0] sum;
  logic [HB-1:0] low_h;

  always_comb begin
    fin   = dly_q[DLY-1];
    sum   = (HB+2)'(fin.best_h) + (HB+2)'(quo);
    low_h = (ovf || sum > (HB+2)'(HMAX)) ? HMAX : sum[HB-1:0];
  end

  logic          done_q;
  logic [1:0]    outcome_q;
  logic [HB-1:0] new_h_q, new_orig_q;
  logic          new_marked_q;
  logic [RW-1:0] new_stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dly_vld_q[DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    outcome_q    <= fin.outcome;
    new_h_q      <= (fin.outcome == OUT_FAIL) ? low_h : fin.h;
    new_marked_q <= fin.marked;
    new_orig_q   <= fin.orig;
    new_stable_q <= fin.stable;
  end

  assign done_o             = done_q;
  assign outcome_o          = outcome_q;
  assign new_height_o       = new_h_q;
  assign new_marked_o       = new_marked_q;
  assign new_original_o     = new_orig_q;
  assign new_stable_slope_o = new_stable_q;

endmodule

`default_nettype wire

// ===== rtl/tcsf_lane.sv =====
// One neighbour lane: usability test and slope product, registered.
// Depends on tcsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcsf_lane (
  input  wire logic                  clk_i,
  input  wire logic [tcsf_pkg::HB-1:0]   h_i,
  input  wire logic [tcsf_pkg::NB_W-1:0] nb_i,
  input  wire logic [tcsf_pkg::RW-1:0]   recip_i,
  output tcsf_pkg::lane_t                lane_o
);
  import tcsf_pkg::*;

  logic [HB-1:0] nh;
  logic          usable;
  logic [HB-1:0] drop;
  lane_t         lane_d, lane_q;

  // Usable: nonzero, unmarked and strictly below the center
  always_comb begin
    nh     = nb_i[HB-1:0];
    usable = (nh != '0) && !nb_i[HB] && (nh < h_i);
    drop   = h_i - nh;
    lane_d.nh    = nh;
    lane_d.recip = recip_i;
    lane_d.prod  = usable ? (PROD_W'(drop) * PROD_W'(recip_i)) : '0;
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

// ===== rtl/tcsf_merge.sv =====
// Registered three-level tree that picks the steepest lane; on equal slopes
// the lower lane index wins. Depends on tcsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcsf_merge (
  input  wire logic            clk_i,
  input  wire tcsf_pkg::lane_t lane_i [tcsf_pkg::NUM_NB],
  output tcsf_pkg::lane_t      win_o
);
  import tcsf_pkg::*;

  lane_t l1_q [4];
  lane_t l2_q [2];
  lane_t l3_q;

  // Take the later one only when strictly steeper
  function automatic lane_t pick(input lane_t a, input lane_t b);
    return (b.prod > a.prod) ? b : a;
  endfunction

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      l1_q[i] <= pick(lane_i[2*i], lane_i[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l2_q[i] <= pick(l1_q[2*i], l1_q[2*i+1]);
    end
    l3_q <= pick(l2_q[0], l2_q[1]);
  end

  assign win_o = l3_q;

endmodule

`default_nettype wire

// ===== rtl/tcsf_div.sv =====
// Pipelined restoring divider: floor(dvd * 4096 / dvs), one quotient bit per
// stage, with an overflow flag when the quotient needs more than QB bits.
// Depends on tcsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcsf_div (
  input  wire logic                   clk_i,
  input  wire logic [tcsf_pkg::RW-1:0] dvd_i,
  input  wire logic [tcsf_pkg::RW-1:0] dvs_i,
  output logic      [tcsf_pkg::QB-1:0] quo_o,
  output logic                        ovf_o
);
  import tcsf_pkg::*;

  logic [REM_W-1:0] rem_q [QB];
  logic [NUM_W-1:0] num_q [QB];
  logic [RW-1:0]    dvs_q [QB];
  logic [QB-1:0]    quo_q [QB+1];
  logic             ovf_q [QB+1];

  logic [NUM_W-1:0] num0;
  logic [REM_W-1:0] top0;

  // Entry: the leading part of the dividend, overflow if it reaches dvs
  always_comb begin
    num0 = {dvd_i, 12'b0};
    top0 = REM_W'(num0[NUM_W-1:QB]);
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= top0;
    num_q[0] <= num0;
    dvs_q[0] <= dvs_i;
    quo_q[0] <= '0;
    ovf_q[0] <= (top0 >= {1'b0, dvs_i});
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [REM_W-1:0] t;
    logic             ge;

    always_comb begin
      t  = {rem_q[k-1][RW-1:0], num_q[k-1][QB-k]};
      ge = (t >= {1'b0, dvs_q[k-1]});
    end

    always_ff @(posedge clk_i) begin
      quo_q[k] <= {quo_q[k-1][QB-2:0], ge};
      ovf_q[k] <= ovf_q[k-1];
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? (t - {1'b0, dvs_q[k-1]}) : t;
        num_q[k] <= num_q[k-1];
        dvs_q[k] <= dvs_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

`default_nettype wire

// ===== rtl/tcsf_checker.sv =====
// Port-level checker for the slope-failure core, bound to the top level.
// Depends on tcsf_pkg and terrain_cell_slope_failure_core.
`timescale 1ns / 1ps
`default_nettype none

module tcsf_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start_i,
  input wire logic                    busy_o,
  input wire logic [tcsf_pkg::HB-1:0] center_height_i,
  input wire logic                    done_o,
  input wire logic [1:0]              outcome_o,
  input wire logic [tcsf_pkg::HB-1:0] new_height_o,
  input wire logic                    new_marked_o,
  input wire logic [tcsf_pkg::HB-1:0] new_original_o
);
  import tcsf_pkg::*;

  // Every taken word comes out as a result strobe, and no strobe comes without one
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start_i && !busy_o, LAT))
    else $error("result strobe does not match accepted word");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (outcome_o == OUT_NONE || outcome_o == OUT_STABLE ||
                outcome_o == OUT_FAIL))
    else $error("undefined outcome code");

  // Only a failure changes the height
  a_keep_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o != OUT_FAIL) |->
      new_height_o == $past(center_height_i, LAT))
    else $error("height changed without failure");

  // A failed cell is unmarked and has a saved original height
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == OUT_FAIL) |-> (!new_marked_o && new_original_o != '0))
    else $error("failed cell left marked or without original");

endmodule

bind terrain_cell_slope_failure_core tcsf_checker u_tcsf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .center_height_i(center_height_i),
  .done_o         (done_o),
  .outcome_o      (outcome_o),
  .new_height_o   (new_height_o),
  .new_marked_o   (new_marked_o),
  .new_original_o (new_original_o)
);

`default_nettype wire
